[src/satlb_pkg.sv]
// shared types and constants for the set-associative tlb core
`default_nettype none
package satlb_pkg;
   localparam int unsigned TICK_W = 48;
   localparam int unsigned CTX_W = 4;
   localparam int unsigned PB_W = 5;
   localparam int unsigned LAT_W = 16;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_LAT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_LAT = 2'd2;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef logic [TICK_W-1:0] tick_type;

   // one way of a set as kept in memory
   typedef struct packed {
      logic valid;
      logic mark;
      logic [CTX_W-1:0] ctx;
      tick_type tag;
      tick_type rdy;
   } way_type;
endpackage
`default_nettype wire

[src/set_assoc_tlb_bit_plru_core.sv]
// set-associative tlb tag store with bit-plru replacement, top level
// lookup: request beat to response passes set read, compare,
// write-back and response register; one item in flight, next request taken after the response
// flush: each set in turn is read and written back, then the response beat is registered
// reset clears the set memory by a pass over all SETS sets, no request taken then
// set memory: one row of WAYS entries plus fill and clear-mark counts per set
`default_nettype none
module set_assoc_tlb_bit_plru_core #(
   parameter int unsigned SETS = 16,
   parameter int unsigned WAYS = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic req_opcode,
   input  wire logic [47:0] req_virtual_address,
   input  wire logic [3:0] req_context_id,
   input  wire logic [47:0] req_request_tick,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_hit,
   output logic [47:0] rsp_completion_tick,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [31:0] csr_data
);
   import satlb_pkg::*;

   localparam int unsigned SB = (SETS > 1) ? $clog2(SETS + 1) - 1 : 0;
   localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int unsigned CW = $clog2(WAYS + 1);
   localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef struct packed {
      logic [CW-1:0] filled;
      logic [CW-1:0] clear;
      way_type [WAYS-1:0] ways;
   } row_type;

   localparam logic [2:0] ST_CLR   = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RD    = 3'd2;
   localparam logic [2:0] ST_WB    = 3'd3;
   localparam logic [2:0] ST_RSP   = 3'd4;

   row_type mem [SETS];
   row_type rd_ff;
   logic [2:0] st_ff;
   logic [SW-1:0] set_ff;
   logic op_ff;
   logic [CTX_W-1:0] ctx_ff;
   tick_type vpn_ff, now_ff, best_ff;
   logic [PB_W-1:0] pb_ff;
   logic [LAT_W-1:0] hl_ff, ml_ff;
   logic rv_ff, rh_ff;
   tick_type rt_ff;
   logic we;
   row_type wrow;
   logic hit_c;
   tick_type done_c, latest_c;

   assign csr_ready = 1'b1;
   assign req_ready = (st_ff == ST_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_hit = rh_ff;
   assign rsp_completion_tick = rt_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pb_ff <= PB_W'(12);
         hl_ff <= LAT_W'(1);
         ml_ff <= LAT_W'(100);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PAGE_BITS: pb_ff <= csr_data[PB_W-1:0];
            CSR_HIT_LAT: hl_ff <= csr_data[LAT_W-1:0];
            CSR_MISS_LAT: ml_ff <= csr_data[LAT_W-1:0];
            default: ;
         endcase
      end
   end

   // set index and page number from the address
   logic [SW-1:0] set_c;
   tick_type vpn_c;
   always_comb begin
      tick_type sh;
      sh = req_virtual_address >> pb_ff;
      set_c = (SB == 0) ? '0 : SW'(sh & ((TICK_W'(1) << SB) - 1));
      vpn_c = sh >> SB;
   end

   // row modify: lookup or flush of the row read
   always_comb begin
      row_type r;
      logic found, vm;
      logic [WW-1:0] hw, vic;
      logic [CW-1:0] k, c;
      tick_type old;
      r = rd_ff;
      wrow = rd_ff;
      found = 1'b0;
      hw = '0;
      vic = '0;
      vm = 1'b0;
      old = '0;
      k = '0;
      c = '0;
      latest_c = best_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && r.ways[w].valid && r.ways[w].tag == vpn_ff && r.ways[w].ctx == ctx_ff) begin
            found = 1'b1;
            hw = WW'(w);
         end
      end
      for (int w = WAYS - 1; w >= 0; w--)
         if (!r.ways[w].mark) vic = WW'(w);
      if (!found) begin
         if (r.filled < CW'(WAYS)) begin
            vic = WW'(r.filled);
            wrow.filled = r.filled + 1'b1;
         end else if (WAYS == 1) vic = '0;
         hw = vic;
      end
      hit_c = found;
      old = r.ways[hw].rdy;
      done_c = ((now_ff > old) ? now_ff : old) + TICK_W'(hl_ff);
      // plru touch
      vm = r.ways[hw].mark;
      if (!vm) begin
         if (r.clear <= CW'(1)) begin
            for (int w = 0; w < WAYS; w++) wrow.ways[w].mark = 1'b0;
            wrow.clear = CW'(WAYS - 1);
         end else wrow.clear = r.clear - 1'b1;
      end
      wrow.ways[hw].mark = 1'b1;
      if (!found) begin
         wrow.ways[hw].tag = vpn_ff;
         wrow.ways[hw].ctx = ctx_ff;
         wrow.ways[hw].valid = 1'b1;
         wrow.ways[hw].rdy = done_c + TICK_W'(ml_ff);
      end
      // flush compaction
      if (op_ff == OP_FLUSH) begin
         for (int w = 0; w < WAYS; w++) wrow.ways[w] = '0;
         for (int w = 0; w < WAYS; w++) begin
            if (r.ways[w].valid) begin
               if (r.ways[w].ctx == ctx_ff) begin
                  if (r.ways[w].rdy > latest_c) latest_c = r.ways[w].rdy;
               end else begin
                  wrow.ways[k[WW-1:0]] = r.ways[w];
                  k = k + 1'b1;
               end
            end
         end
         for (int w = 0; w < WAYS; w++)
            if (!wrow.ways[w].mark) c = c + 1'b1;
         wrow.filled = k;
         wrow.clear = c;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLR;
         set_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         unique case (st_ff)
            ST_CLR: begin
               if (set_ff == SW'(SETS - 1)) begin
                  st_ff <= ST_IDLE;
               end
               set_ff <= (set_ff == SW'(SETS - 1)) ? '0 : set_ff + 1'b1;
            end
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  st_ff <= ST_RD;
                  set_ff <= (req_opcode == OP_FLUSH) ? '0 : set_c;
               end
            end
            ST_RD: st_ff <= ST_WB;
            ST_WB: begin
               if (op_ff == OP_FLUSH && set_ff != SW'(SETS - 1)) begin
                  set_ff <= set_ff + 1'b1;
                  st_ff <= ST_RD;
               end else st_ff <= ST_RSP;
            end
            ST_RSP: begin
               rv_ff <= 1'b1;
               st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff <= req_opcode;
         ctx_ff <= req_context_id;
         vpn_ff <= vpn_c;
         now_ff <= req_request_tick;
         best_ff <= '0;
      end
      if (st_ff == ST_WB) begin
         best_ff <= latest_c;
         rh_ff <= (op_ff == OP_LOOKUP) && hit_c;
         rt_ff <= (op_ff == OP_FLUSH) ? latest_c : done_c;
      end
   end

   // set memory, one read and one write port
   assign we = (st_ff == ST_WB) || (st_ff == ST_CLR);
   always_ff @(posedge clock) begin
      if (we) begin
         if (st_ff == ST_CLR) mem[set_ff] <= '{filled: '0, clear: CW'(WAYS), ways: '0};
         else mem[set_ff] <= wrow;
      end
      rd_ff <= mem[set_ff];
   end

`ifndef SYNTH
   // a response is raised only from the response state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(st_ff) == ST_RSP) else $error("stray response");
   // no request taken during the clearing pass
   a_clr_block: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_CLR |-> !req_ready) else $error("request in clear pass");
   // a hit never comes from a flush
   a_flush_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && op_ff == OP_FLUSH) |-> !rsp_hit) else $error("flush hit");
`endif
endmodule
`default_nettype wire
